// ===== hdl/vignette_background_pixel_core_assert.svh =====
// Assertion macros for the vignette background pixel core.
// Depends on a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef VIGNETTE_BACKGROUND_PIXEL_CORE_ASSERT_SVH
`define VIGNETTE_BACKGROUND_PIXEL_CORE_ASSERT_SVH

// Same-cycle implication.
`define VBP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VBP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/vbp_pkg.sv =====
// Package for the vignette background pixel core: widths, types, register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vbp_pkg;

    localparam int MAX_SIDE = 4096;
    localparam int SIDE_W   = 13;   // frame size register width
    localparam int PIX_W    = 12;   // pixel coordinate width
    localparam int COORD_W  = 20;   // Q.8 coordinates and distances
    localparam int SQ_W     = 40;   // one squared term
    localparam int RAD_W    = 42;   // radicand, even width
    localparam int ROOT_W   = RAD_W / 2;
    localparam int SQ_REM_W = ROOT_W + 1;
    localparam int DIV_W    = 20;   // divider lane width
    localparam int QUOT_W   = 16;   // Q0.16 quotient bits
    localparam int CY_MUL   = 171798692;  // ceil(2^32 / 25)

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [RAD_W-1:0]    rad;
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
    } t_sq_lane;

    typedef struct packed {
        t_sq_lane          pix_lane;
        t_sq_lane          corner;
        logic [PIX_W-1:0]  py;
        logic [PIX_W-1:0]  hm1;
    } t_root_item;

    typedef struct packed {
        logic [DIV_W-1:0]  rem;
        logic [DIV_W-1:0]  dvs;
        logic [QUOT_W-1:0] quot;
    } t_div_lane;

    typedef struct packed {
        logic glow_zero;
        logic vert_zero;
        logic vert_one;
        logic scan;
    } t_div_flags;

    typedef struct packed {
        t_div_lane  glow;
        t_div_lane  vert;
        t_div_flags flags;
    } t_div_item;

    // Size register as used: 0 reads as 1, above MAX_SIDE as MAX_SIDE.
    function automatic logic [SIDE_W-1:0] side_used(input logic [SIDE_W-1:0] v);
        if (v == '0) begin
            return SIDE_W'(1);
        end else if (v > SIDE_W'(MAX_SIDE)) begin
            return SIDE_W'(MAX_SIDE);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/vbp_root_cell.sv =====
// One cell of the square-root chain: one result bit for distance and corner lanes.
// Depends on vbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vbp_root_cell
    import vbp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic       i_valid,
    input  wire t_root_item i_item,
    output logic            o_valid,
    output t_root_item      o_item
);

    logic       r_valid;
    t_root_item r_item;
    t_root_item n_item;

    function automatic t_sq_lane f_step(input t_sq_lane a);
        logic [SQ_REM_W+1:0] cand;
        logic [SQ_REM_W+1:0] trial;
        t_sq_lane            r;
        cand  = {a.rem, a.rad[RAD_W-1 -: 2]};
        trial = {1'b0, a.root, 2'b01};
        r.rad = {a.rad[RAD_W-3:0], 2'b00};
        if (cand >= trial) begin
            r.rem  = SQ_REM_W'(cand - trial);
            r.root = {a.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = cand[SQ_REM_W-1:0];
            r.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb begin
        n_item          = i_item;
        n_item.pix_lane = f_step(i_item.pix_lane);
        n_item.corner   = f_step(i_item.corner);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== hdl/vbp_div_cell.sv =====
// One cell of the divider chain: one quotient bit for the glow and vertical lanes.
// Depends on vbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vbp_div_cell
    import vbp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire logic      i_valid,
    input  wire t_div_item i_item,
    output logic           o_valid,
    output t_div_item      o_item
);

    logic      r_valid;
    t_div_item r_item;
    t_div_item n_item;

    // Restoring step; remainder stays below the divisor.
    function automatic t_div_lane f_step(input t_div_lane a);
        logic [DIV_W:0] sh;
        t_div_lane      r;
        sh    = {a.rem, 1'b0};
        r.dvs = a.dvs;
        if (sh >= {1'b0, a.dvs}) begin
            r.rem  = DIV_W'(sh - {1'b0, a.dvs});
            r.quot = {a.quot[QUOT_W-2:0], 1'b1};
        end else begin
            r.rem  = sh[DIV_W-1:0];
            r.quot = {a.quot[QUOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb begin
        n_item      = i_item;
        n_item.glow = f_step(i_item.glow);
        n_item.vert = f_step(i_item.vert);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== hdl/vignette_background_pixel_core.sv =====
// Top level of the vignette background pixel core: front end, cell chains, colour stage.
// Depends on vbp_pkg, vbp_root_cell, vbp_div_cell and the assertion macro header.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------
//  pixel   | i_valid / o_ready     | i_pixel_x[11:0], i_pixel_y[11:0]
//  colour  | o_valid / i_ready     | o_red[7:0], o_green[7:0], o_blue[7:0]
//  config  | i_cfg_we (no wait)    | i_cfg_idx[0:0], i_cfg_data[12:0]
//
// Throughput is one pixel transaction per clock while i_ready keeps the output
// moving; the pipeline is the 21 square-root cells and the 16 divider cells plus
// five front and back stages. Each stage moves when it is empty or the stage after
// it moves, so bubbles close up behind a stalled output. Reset is synchronous,
// active low, and clears the stage valids and sets the frame to 320 x 180.
`timescale 1ns / 1ps
`default_nettype none

`include "vignette_background_pixel_core_assert.svh"

module vignette_background_pixel_core
    import vbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [PIX_W-1:0]  i_pixel_x,
    input  wire logic [PIX_W-1:0]  i_pixel_y,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_red,
    output logic [7:0]             o_green,
    output logic [7:0]             o_blue,
    input  wire logic              i_cfg_we,
    input  wire t_cfg_idx          i_cfg_idx,
    input  wire logic [SIDE_W-1:0] i_cfg_data
);

    localparam int ONE_Q16 = 65536;
    localparam int SUM_W   = 22;

    // ---------------------------------------------------------------
    // Configuration: the frame size is kept as derived centre values.
    // cx = w * 128, cy = round(0.48 * 256 * h), hm1 = h - 1.
    // ---------------------------------------------------------------
    logic [COORD_W-1:0] r_cx;
    logic [COORD_W-1:0] r_cy;
    logic [PIX_W-1:0]   r_hm1;
    logic [SIDE_W-1:0]  cfg_side;
    logic [23:0]        cy_num;
    logic [51:0]        cy_prod;

    assign cfg_side = side_used(i_cfg_data);
    assign cy_num   = 24'(cfg_side) * 24'd3072 + 24'd12;
    assign cy_prod  = 52'(cy_num) * 52'(CY_MUL);   // /25 by reciprocal

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= COORD_W'(40960);
            r_cy  <= COORD_W'(22118);
            r_hm1 <= PIX_W'(179);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH: begin
                    r_cx <= {cfg_side, 7'b0};
                end
                CFG_FRAME_HEIGHT: begin
                    r_cy  <= cy_prod[51:32];
                    r_hm1 <= PIX_W'(cfg_side - SIDE_W'(1));
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage enables: a stage loads when empty or when its successor loads.
    // ---------------------------------------------------------------
    localparam int ROOT_N = ROOT_W;
    localparam int DIV_N  = QUOT_W;

    logic               en_s1, en_s2, en_s3, en_pr, en_out;
    logic [ROOT_N-1:0]  root_en, root_v;
    logic [DIV_N-1:0]   div_en, div_v;
    t_root_item         root_q [ROOT_N];
    t_div_item          div_q  [DIV_N];

    // Stage 1: offsets from centre.
    logic               r_s1_valid;
    logic [COORD_W-1:0] r_s1_dx, r_s1_dy, r_s1_cx, r_s1_cy;
    logic [PIX_W-1:0]   r_s1_py, r_s1_hm1;
    logic [COORD_W-1:0] px_q8, py_q8;

    // Stage 2: squares.
    logic               r_s2_valid;
    logic [SQ_W-1:0]    r_s2_dx2, r_s2_dy2, r_s2_cx2, r_s2_cy2;
    logic [PIX_W-1:0]   r_s2_py, r_s2_hm1;

    // Stage 3: radicands, head of the root chain.
    logic               r_s3_valid;
    t_root_item         r_s3;

    // Divider set-up stage.
    logic               r_pr_valid;
    t_div_item          r_pr;
    t_div_item          n_pr;
    t_root_item         root_last;

    // Output register.
    logic               r_out_valid;
    logic [7:0]         r_red, r_green, r_blue;

    assign en_out  = !r_out_valid || i_ready;
    assign en_pr   = !r_pr_valid || div_en[0];
    assign en_s3   = !r_s3_valid || root_en[0];
    assign en_s2   = !r_s2_valid || en_s3;
    assign en_s1   = !r_s1_valid || en_s2;
    assign o_ready = en_s1;

    assign px_q8 = {i_pixel_x, 8'b0};
    assign py_q8 = {i_pixel_y, 8'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_pr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_s1)  r_s1_valid  <= i_valid;
            if (en_s2)  r_s2_valid  <= r_s1_valid;
            if (en_s3)  r_s3_valid  <= r_s2_valid;
            if (en_pr)  r_pr_valid  <= root_v[ROOT_N-1];
            if (en_out) r_out_valid <= div_v[DIV_N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1_dx  <= (px_q8 >= r_cx) ? px_q8 - r_cx : r_cx - px_q8;
            r_s1_dy  <= (py_q8 >= r_cy) ? py_q8 - r_cy : r_cy - py_q8;
            r_s1_cx  <= r_cx;
            r_s1_cy  <= r_cy;
            r_s1_py  <= i_pixel_y;
            r_s1_hm1 <= r_hm1;
        end
        if (en_s2) begin
            r_s2_dx2 <= SQ_W'(r_s1_dx) * SQ_W'(r_s1_dx);
            r_s2_dy2 <= SQ_W'(r_s1_dy) * SQ_W'(r_s1_dy);
            r_s2_cx2 <= SQ_W'(r_s1_cx) * SQ_W'(r_s1_cx);
            r_s2_cy2 <= SQ_W'(r_s1_cy) * SQ_W'(r_s1_cy);
            r_s2_py  <= r_s1_py;
            r_s2_hm1 <= r_s1_hm1;
        end
        if (en_s3) begin
            r_s3.pix_lane.rad  <= RAD_W'(r_s2_dx2) + RAD_W'(r_s2_dy2);
            r_s3.pix_lane.rem  <= '0;
            r_s3.pix_lane.root <= '0;
            r_s3.corner.rad    <= RAD_W'(r_s2_cx2) + RAD_W'(r_s2_cy2);
            r_s3.corner.rem    <= '0;
            r_s3.corner.root   <= '0;
            r_s3.py            <= r_s2_py;
            r_s3.hm1           <= r_s2_hm1;
        end
    end

    // ---------------------------------------------------------------
    // Square-root chain: one bit of both roots per cell.
    // ---------------------------------------------------------------
    genvar k;
    generate
        for (k = 0; k < ROOT_N; k++) begin : g_root
            logic       cell_v;
            t_root_item cell_d;
            if (k == 0) begin : g_head
                assign cell_v = r_s3_valid;
                assign cell_d = r_s3;
            end else begin : g_body
                assign cell_v = root_v[k-1];
                assign cell_d = root_q[k-1];
            end
            if (k == ROOT_N - 1) begin : g_tail_en
                assign root_en[k] = !root_v[k] || en_pr;
            end else begin : g_body_en
                assign root_en[k] = !root_v[k] || root_en[k+1];
            end
            vbp_root_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (root_en[k]),
                .i_valid (cell_v),
                .i_item  (cell_d),
                .o_valid (root_v[k]),
                .o_item  (root_q[k])
            );
        end
    endgenerate

    assign root_last = root_q[ROOT_N-1];

    // Divider set-up: outside the unit circle glow is zero, on or past the last
    // row vertical saturates, and a single-row frame gives no vertical term.
    always_comb begin
        n_pr.flags.glow_zero = root_last.pix_lane.root >= root_last.corner.root;
        n_pr.flags.vert_zero = root_last.hm1 == '0;
        n_pr.flags.vert_one  = root_last.py >= root_last.hm1;
        n_pr.flags.scan      = root_last.py[1:0] == 2'b00;
        n_pr.glow.rem  = n_pr.flags.glow_zero ? '0 : root_last.pix_lane.root[DIV_W-1:0];
        n_pr.glow.dvs  = root_last.corner.root[DIV_W-1:0];
        n_pr.glow.quot = '0;
        n_pr.vert.rem  = n_pr.flags.vert_one ? '0 : DIV_W'(root_last.py);
        n_pr.vert.dvs  = DIV_W'(root_last.hm1);
        n_pr.vert.quot = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en_pr) begin
            r_pr <= n_pr;
        end
    end

    // ---------------------------------------------------------------
    // Divider chain: one Q0.16 bit of ratio and vertical per cell.
    // ---------------------------------------------------------------
    generate
        for (k = 0; k < DIV_N; k++) begin : g_div
            logic      cell_v;
            t_div_item cell_d;
            if (k == 0) begin : g_head
                assign cell_v = r_pr_valid;
                assign cell_d = r_pr;
            end else begin : g_body
                assign cell_v = div_v[k-1];
                assign cell_d = div_q[k-1];
            end
            if (k == DIV_N - 1) begin : g_tail_en
                assign div_en[k] = !div_v[k] || en_out;
            end else begin : g_body_en
                assign div_en[k] = !div_v[k] || div_en[k+1];
            end
            vbp_div_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (div_en[k]),
                .i_valid (cell_v),
                .i_item  (cell_d),
                .o_valid (div_v[k]),
                .o_item  (div_q[k])
            );
        end
    endgenerate

    // ---------------------------------------------------------------
    // Colour stage: base + weighted glow and vertical in Q.16, truncated.
    // Sums never reach 256, so the clamp is a plain zero-extend.
    // ---------------------------------------------------------------
    t_div_item        div_last;
    logic [QUOT_W:0]  glow, vert;
    logic [SUM_W-1:0] sum_r, sum_g, sum_b;

    assign div_last = div_q[DIV_N-1];

    always_comb begin
        glow = div_last.flags.glow_zero ? '0
             : (QUOT_W+1)'(ONE_Q16) - {1'b0, div_last.glow.quot};
        if (div_last.flags.vert_zero) begin
            vert = '0;
        end else if (div_last.flags.vert_one) begin
            vert = (QUOT_W+1)'(ONE_Q16);
        end else begin
            vert = {1'b0, div_last.vert.quot};
        end
        sum_r = SUM_W'(3 * ONE_Q16) + SUM_W'(glow) * SUM_W'(6)
              + (div_last.flags.scan ? SUM_W'(2 * ONE_Q16) : '0);
        sum_g = SUM_W'(7 * ONE_Q16) + SUM_W'(glow) * SUM_W'(11) + SUM_W'(vert) * SUM_W'(3);
        sum_b = SUM_W'(19 * ONE_Q16) + SUM_W'(glow) * SUM_W'(20) + SUM_W'(vert) * SUM_W'(5);
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_red   <= 8'(sum_r[SUM_W-1:16]);
            r_green <= 8'(sum_g[SUM_W-1:16]);
            r_blue  <= 8'(sum_b[SUM_W-1:16]);
        end
    end

    assign o_valid = r_out_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `VBP_ASSERT_IMP(a_ready_only_stalls_full, !o_ready, r_s1_valid && !en_s2,
        "input held off with an empty or moving first stage")
    `VBP_ASSERT_IMP(a_colour_floor, o_valid,
        (o_red >= 8'd3) && (o_green >= 8'd7) && (o_blue >= 8'd19),
        "colour below its base value")
    `VBP_ASSERT_IMP(a_centre_sane, 1'b1, (r_cx >= COORD_W'(128)) && (r_cy >= COORD_W'(122)),
        "centre derived from an unclamped frame size")
    `VBP_ASSERT_NXT(a_out_held, o_valid && !i_ready, o_valid && $stable(o_red),
        "pending colour transaction changed while stalled")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for vignette_background_pixel_core: directed and random pixel transactions
// checked against an in-bench colour predictor. Depends on vbp_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
    import vbp_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int PIPE_DEPTH   = 42;     // latency given by the core
    localparam int WATCHDOG_MAX = 5000;   // idle cycles before the run is abandoned
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_colour;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [PIX_W-1:0]  i_pixel_x = '0;
    logic [PIX_W-1:0]  i_pixel_y = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [7:0]        o_red;
    logic [7:0]        o_green;
    logic [7:0]        o_blue;
    logic              i_cfg_we = 1'b0;
    t_cfg_idx          i_cfg_idx = CFG_FRAME_WIDTH;
    logic [SIDE_W-1:0] i_cfg_data = '0;

    // Local copy of the frame registers as written.
    logic [SIDE_W-1:0] frame_w_reg = SIDE_W'(320);
    logic [SIDE_W-1:0] frame_h_reg = SIDE_W'(180);

    t_colour colour_due[$];
    int      mismatches = 0;
    int      idle_cycles = 0;
    bit      hold_req = 1'b0;
    int      burst_left = 0;

    vignette_background_pixel_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_pixel_x  (i_pixel_x),
        .i_pixel_y  (i_pixel_y),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_red      (o_red),
        .o_green    (o_green),
        .o_blue     (o_blue),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Colour predictor
    // ---------------------------------------------------------------------
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned clamp_side(input logic [SIDE_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return v;
    endfunction

    function automatic logic [7:0] to_channel(input longint unsigned sum_q16);
        longint unsigned c;
        c = sum_q16 >> 16;
        return (c > 255) ? 8'd255 : c[7:0];
    endfunction

    function automatic t_colour pixel_colour(input logic [PIX_W-1:0] px,
                                             input logic [PIX_W-1:0] py);
        longint unsigned w, h, cx, cy, corner, dx, dy, dist_q8, ratio, glow, vert, scan;
        longint unsigned pxq, pyq;
        t_colour c;
        w       = clamp_side(frame_w_reg);
        h       = clamp_side(frame_h_reg);
        cx      = w * 128;
        cy      = (h * 3072 + 12) / 25;
        corner  = int_sqrt(cx * cx + cy * cy);
        pxq     = longint'(px) << 8;
        pyq     = longint'(py) << 8;
        dx      = (pxq >= cx) ? pxq - cx : cx - pxq;
        dy      = (pyq >= cy) ? pyq - cy : cy - pyq;
        dist_q8 = int_sqrt(dx * dx + dy * dy);
        ratio   = (dist_q8 << 16) / corner;
        glow    = (ratio < 65536) ? 65536 - ratio : 0;
        vert    = 0;
        if (h > 1) begin
            vert = (longint'(py) << 16) / (h - 1);
            if (vert > 65536) vert = 65536;
        end
        scan    = (py[1:0] == 2'b00) ? 2 : 0;
        c.red   = to_channel(3 * 65536 + 6 * glow + scan * 65536);
        c.green = to_channel(7 * 65536 + 11 * glow + 3 * vert);
        c.blue  = to_channel(19 * 65536 + 20 * glow + 5 * vert);
        return c;
    endfunction

    // ---------------------------------------------------------------------
    // Receiver: stall pattern changes every so often; long hold-off on request
    // ---------------------------------------------------------------------
    initial begin : receiver
        int mode;
        int left;
        int hold;
        mode = 0;
        left = 0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && hold == 0) begin
                hold     = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    0: i_ready <= 1'b1;                           // no stalls
                    1: i_ready <= ($urandom_range(0, 9) < 7);
                    2: i_ready <= ($urandom_range(0, 9) < 3);
                    default: i_ready <= ~i_ready;                 // toggling
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result checker: compare each colour transaction with the oldest due colour
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_colour exp_c;
        if (i_rst_n && o_valid && i_ready) begin
            if (colour_due.size() == 0) begin
                $display("%0t: unexpected colour r=%0d g=%0d b=%0d",
                         $time, o_red, o_green, o_blue);
                mismatches++;
            end else begin
                exp_c = colour_due.pop_front();
                if (o_red !== exp_c.red) begin
                    $display("%0t: red expected %0d actual %0d", $time, exp_c.red, o_red);
                    mismatches++;
                end
                if (o_green !== exp_c.green) begin
                    $display("%0t: green expected %0d actual %0d",
                             $time, exp_c.green, o_green);
                    mismatches++;
                end
                if (o_blue !== exp_c.blue) begin
                    $display("%0t: blue expected %0d actual %0d", $time, exp_c.blue, o_blue);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("vignette_background_pixel_core verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Shared stimulus tasks
    // ---------------------------------------------------------------------
    // Sends one pixel; called just after a rising edge. Valid stays high within
    // a burst, and a random gap, which may be zero, follows when the burst runs out.
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        int gap;
        i_valid   <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        do @(posedge i_clk); while (!o_ready);
        colour_due.push_back(pixel_colour(px, py));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Sender idle until every due colour has come out.
    task automatic wait_drained();
        i_valid   <= 1'b0;
        burst_left = 0;
        while (colour_due.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
    endtask

    // Register write while idle.
    task automatic write_frame(input t_cfg_idx idx, input logic [SIDE_W-1:0] val);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FRAME_WIDTH) frame_w_reg = val;
        else frame_h_reg = val;
    endtask

    // Mostly pixels inside the frame, some anywhere in the coordinate range.
    task automatic send_random(input int n);
        longint unsigned w, h;
        w = clamp_side(frame_w_reg);
        h = clamp_side(frame_h_reg);
        repeat (n) begin
            if ($urandom_range(0, 9) < 8) begin
                send_pixel(PIX_W'($urandom_range(0, int'(w) - 1)),
                           PIX_W'($urandom_range(0, int'(h) - 1)));
            end else begin
                send_pixel(PIX_W'($urandom), PIX_W'($urandom));
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    task automatic test_reset_frame_directed();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd160, 12'd86);       // centre
        send_pixel(12'd319, 12'd179);
        send_pixel(12'd0, 12'd4095);       // far outside, vertical saturates
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd5, 12'd1);
        send_pixel(12'd5, 12'd2);
        send_pixel(12'd5, 12'd3);
        send_pixel(12'd2730, 12'd1365);
    endtask

    task automatic test_size_extremes();
        write_frame(CFG_FRAME_WIDTH, '0);          // zero used as one
        write_frame(CFG_FRAME_HEIGHT, '0);         // height of one
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd4);
        send_pixel(12'd4095, 12'd4095);
        write_frame(CFG_FRAME_WIDTH, 13'h1FFF);    // above the maximum side
        write_frame(CFG_FRAME_HEIGHT, 13'd4096);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd2048, 12'd1966);
        send_pixel(12'd4095, 12'd4095);
        write_frame(CFG_FRAME_HEIGHT, 13'd1);
        send_pixel(12'd100, 12'd0);
        write_frame(CFG_FRAME_HEIGHT, 13'd2);
        send_pixel(12'd100, 12'd1);
        send_pixel(12'd100, 12'd2);
    endtask

    task automatic test_random_frames();
        logic [SIDE_W-1:0] sizes [6] = '{13'd1, 13'd2, 13'd320, 13'd4096, 13'd8191, 13'd0};
        for (int phase = 0; phase < 10; phase++) begin
            if (phase < 6) begin
                write_frame(CFG_FRAME_WIDTH, sizes[phase]);
                write_frame(CFG_FRAME_HEIGHT, sizes[5 - phase]);
            end else begin
                write_frame(CFG_FRAME_WIDTH, SIDE_W'($urandom_range(1, 4096)));
                write_frame(CFG_FRAME_HEIGHT, SIDE_W'($urandom_range(1, 4096)));
            end
            send_random(140);
        end
    endtask

    // Receiver holds off while the sender keeps offering, then a full pause.
    task automatic test_backpressure();
        hold_req   = 1'b1;
        burst_left = 150;
        send_random(150);
        wait_drained();
        send_random(80);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_frame_directed();
        test_size_extremes();
        test_random_frames();
        test_backpressure();
        wait_drained();
        if (mismatches == 0) begin
            $display("vignette_background_pixel_core verification clean");
        end else begin
            $display("vignette_background_pixel_core verification failed");
        end
        $finish;
    end

endmodule
